[rtl/core/battery_led_bar_animator_top_macros.svh]
// Assertion macros shared by the checker.
`ifndef BATTERY_LED_BAR_ANIMATOR_TOP_MACROS_SVH
`define BATTERY_LED_BAR_ANIMATOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lba_pkg.sv]
package lba_pkg;

  localparam int unsigned LED_W    = 5;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned SU_W     = 11;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [SU_W-1:0]  SU_END      = 11'd1000;
  localparam logic [SU_W-1:0]  SU_DARK     = 11'd500;
  localparam logic [SU_W-1:0]  SU_MAX      = 11'd2047;
  localparam logic [CFG_W-1:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SET_CHARGE = 3'd1,
    ACT_SET_NUMBER = 3'd2,
    ACT_CHARGING   = 3'd3,
    ACT_CRITICAL   = 3'd4,
    ACT_EMPTY      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    REG_CHARGE_STEP   = 2'd0,
    REG_EMPTY_STEP    = 2'd1,
    REG_CRIT_SPACING  = 2'd2,
    REG_CRIT_BLINK    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] charge_step;
    logic [CFG_W-1:0] empty_step;
    logic [CFG_W-1:0] crit_spacing;
    logic [CFG_W-1:0] crit_blink;
  } cfg_t;

  typedef struct packed {
    action_e          action;
    logic [VAL_W-1:0] charge;
    logic [VAL_W-1:0] number;
    logic             flag;
  } req_t;

  typedef struct packed {
    logic [LED_W-1:0] led;
    logic             startup;
  } res_t;

endpackage

[rtl/core/battery_led_bar_animator_top.sv]
// LED bar animator: each request (a millisecond tick or a set event) returns
// one result with the LED levels and the startup flag. A request is taken every
// cycle unless in_stall_o is high; its result passes through the input register,
// then one state update into the result register. A stalled result holds the input
// register, so one more request can wait behind it. Step times come from four
// 16-bit registers on the APB port at byte addresses 0, 4, 8 and 12.
module battery_led_bar_animator_top #(
  parameter int unsigned LED_COUNT = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          action_i,
  input  logic [lba_pkg::VAL_W-1:0]           charge_percent_i,
  input  logic [lba_pkg::VAL_W-1:0]           number_value_i,
  input  logic                                flag_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lba_pkg::LED_W-1:0]           led_pattern_o,
  output logic                                in_startup_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lba_pkg::APB_AW-1:0]          paddr,
  input  logic [lba_pkg::APB_DW-1:0]          pwdata,
  output logic [lba_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import lba_pkg::*;

  cfg_t  cfg;
  req_t  req_q;
  res_t  res_d, res_q;
  logic  req_valid_q;
  logic  out_valid_q;
  logic  fire;
  logic  load;

  assign fire       = req_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = req_valid_q && !fire;
  assign load       = in_valid_i && !in_stall_o;

  lba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lba_engine #(
    .LED_COUNT (LED_COUNT)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        req_valid_q <= 1'b1;
      end else if (fire) begin
        req_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.action <= action_e'(action_i);
      req_q.charge <= charge_percent_i;
      req_q.number <= number_value_i;
      req_q.flag   <= flag_value_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_pattern_o = res_q.led;
  assign in_startup_o  = res_q.startup;

endmodule

[rtl/core/lba_cfg.sv]
module lba_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lba_pkg::APB_AW-1:0]  paddr,
  input  logic [lba_pkg::APB_DW-1:0]  pwdata,
  output logic [lba_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output lba_pkg::cfg_t               cfg_o
);
  import lba_pkg::*;

  cfg_t             cfg_q, cfg_d;
  reg_idx_e         idx;
  logic             wr_en;
  logic [CFG_W-1:0] rd_val;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CHARGE_STEP:  cfg_d.charge_step  = pwdata[CFG_W-1:0];
        REG_EMPTY_STEP:   cfg_d.empty_step   = pwdata[CFG_W-1:0];
        REG_CRIT_SPACING: cfg_d.crit_spacing = pwdata[CFG_W-1:0];
        REG_CRIT_BLINK:   cfg_d.crit_blink   = pwdata[CFG_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CHARGE_STEP:  rd_val = cfg_q.charge_step;
      REG_EMPTY_STEP:   rd_val = cfg_q.empty_step;
      REG_CRIT_SPACING: rd_val = cfg_q.crit_spacing;
      REG_CRIT_BLINK:   rd_val = cfg_q.crit_blink;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(APB_DW-CFG_W){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_step  <= 16'd200;
      cfg_q.empty_step   <= 16'd500;
      cfg_q.crit_spacing <= 16'd2000;
      cfg_q.crit_blink   <= 16'd200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/lba_engine.sv]
module lba_engine #(
  parameter int unsigned LED_COUNT = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  lba_pkg::req_t  req_i,
  input  lba_pkg::cfg_t  cfg_i,
  output lba_pkg::res_t  res_o
);
  import lba_pkg::*;

  localparam int unsigned BAR_STEP = 100 / LED_COUNT;
  localparam logic [PHASE_W:0] PHASE_WRAP = (PHASE_W+1)'(LED_COUNT);

  logic [VAL_W-1:0]   charge_q, charge_d;
  logic [VAL_W-1:0]   number_q, number_d;
  logic               mode_q, mode_d;
  logic               chg_on_q, chg_on_d;
  logic               crit_on_q, crit_on_d;
  logic               empty_on_q, empty_on_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CFG_W-1:0]   elapsed_q, elapsed_d;
  logic               su_active_q, su_active_d;
  logic [SU_W-1:0]    su_elapsed_q, su_elapsed_d;
  logic [LED_W-1:0]   pins_q, pins_d;

  logic               run;
  logic [7:0]         bars;
  logic [7:0]         mask;
  logic [PHASE_W:0]   phase_nxt;

  always_comb begin
    charge_d     = charge_q;
    number_d     = number_q;
    mode_d       = mode_q;
    chg_on_d     = chg_on_q;
    crit_on_d    = crit_on_q;
    empty_on_d   = empty_on_q;
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    su_active_d  = su_active_q;
    su_elapsed_d = su_elapsed_q;
    pins_d       = pins_q;
    run          = 1'b1;
    bars         = '0;
    mask         = '0;
    phase_nxt    = '0;

    case (req_i.action)
      ACT_TICK: begin
        if (elapsed_q != ELAPSED_MAX) elapsed_d = elapsed_q + 1'b1;
        if (su_active_q && su_elapsed_q != SU_MAX) su_elapsed_d = su_elapsed_q + 1'b1;
      end
      ACT_SET_CHARGE: begin
        charge_d  = req_i.charge;
        mode_d    = 1'b1;
        phase_d   = '0;
        elapsed_d = '0;
      end
      ACT_SET_NUMBER: begin
        number_d  = req_i.number;
        mode_d    = 1'b0;
        phase_d   = '0;
        elapsed_d = '0;
      end
      ACT_CHARGING: begin
        chg_on_d  = req_i.flag;
        phase_d   = '0;
        elapsed_d = '0;
      end
      ACT_CRITICAL: begin
        crit_on_d = req_i.flag;
        phase_d   = '0;
        elapsed_d = '0;
      end
      ACT_EMPTY: begin
        empty_on_d = req_i.flag;
        phase_d    = '0;
        elapsed_d  = '0;
      end
      default: run = 1'b0;
    endcase

    for (int unsigned i = 0; i < 8; i++) begin
      if (i < LED_COUNT && {24'd0, charge_d} > i * BAR_STEP) bars[i] = 1'b1;
    end

    if (run) begin
      if (su_active_d) begin
        if (su_elapsed_d > SU_END) begin
          su_active_d = 1'b0;
        end else if (su_elapsed_d > SU_DARK) begin
          pins_d = '0;
        end else begin
          pins_d = '1;
        end
      end else if (mode_d) begin
        if (chg_on_d) begin
          if (elapsed_d > cfg_i.charge_step) begin
            phase_nxt = {1'b0, phase_d} + 1'b1;
            phase_d   = (phase_nxt >= PHASE_WRAP) ? '0 : phase_nxt[PHASE_W-1:0];
            elapsed_d = '0;
          end
          for (int unsigned i = 0; i < 8; i++) begin
            mask[i] = ({29'd0, phase_d} > i);
          end
          bars = bars & mask;
        end else if (empty_on_d) begin
          if (elapsed_d > cfg_i.empty_step) begin
            phase_d   = (phase_d == '0) ? PHASE_W'(1) : '0;
            elapsed_d = '0;
          end
          if (phase_d == '0) bars = '0;
        end else if (crit_on_d) begin
          if (phase_d == '0) begin
            if (elapsed_d > cfg_i.crit_spacing) begin
              phase_d   = PHASE_W'(1);
              elapsed_d = '0;
            end
          end else if (phase_d == PHASE_W'(1)) begin
            bars = '0;
            if (elapsed_d > cfg_i.crit_blink) begin
              phase_d   = '0;
              elapsed_d = '0;
            end
          end
        end
        pins_d = bars[LED_W-1:0];
      end else begin
        pins_d = number_d[LED_W-1:0];
      end
    end
  end

  assign res_o.led     = pins_d;
  assign res_o.startup = su_active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_q     <= '0;
      number_q     <= '0;
      mode_q       <= 1'b0;
      chg_on_q     <= 1'b0;
      crit_on_q    <= 1'b0;
      empty_on_q   <= 1'b0;
      phase_q      <= '0;
      elapsed_q    <= '0;
      su_active_q  <= 1'b1;
      su_elapsed_q <= '0;
      pins_q       <= '1;
    end else if (fire_i) begin
      charge_q     <= charge_d;
      number_q     <= number_d;
      mode_q       <= mode_d;
      chg_on_q     <= chg_on_d;
      crit_on_q    <= crit_on_d;
      empty_on_q   <= empty_on_d;
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      su_active_q  <= su_active_d;
      su_elapsed_q <= su_elapsed_d;
      pins_q       <= pins_d;
    end
  end

endmodule

[rtl/core/lba_checker.sv]
module lba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lba_pkg::LED_W-1:0]  led_pattern_o,
  input logic                       in_startup_o
);
  import lba_pkg::*;

`include "battery_led_bar_animator_top_macros.svh"

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && !in_startup_o) begin
      done_q <= 1'b1;
    end
  end

  `LBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(led_pattern_o) && $stable(in_startup_o), "stalled result changed")
  `LBA_ASSERT_NOW(a_startup_ends, out_valid_o && done_q, !in_startup_o, "startup restarted")
  `LBA_ASSERT_NOW(a_startup_pins, out_valid_o && in_startup_o, led_pattern_o == '0 || led_pattern_o == '1, "startup pattern not all on or all off")
  `LBA_ASSERT_NOW(a_no_phantom, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result without a request")

endmodule

bind battery_led_bar_animator_top lba_checker u_lba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .led_pattern_o (led_pattern_o),
  .in_startup_o  (in_startup_o)
);

[test/battery_led_bar_animator_top_test.sv]
`timescale 1ns / 100ps

module battery_led_bar_animator_top_test;
  import lba_pkg::*;

  localparam int unsigned BAR_COUNT   = 5;
  localparam int unsigned STUCK_LIMIT = 1000;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]       action;
    logic [VAL_W-1:0] charge;
    logic [VAL_W-1:0] number;
    logic             flag;
  } bar_req_t;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [2:0]        action_i         = '0;
  logic [VAL_W-1:0]  charge_percent_i = '0;
  logic [VAL_W-1:0]  number_value_i   = '0;
  logic              flag_value_i     = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [LED_W-1:0]  led_pattern_o;
  logic              in_startup_o;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [APB_AW-1:0] paddr            = '0;
  logic [APB_DW-1:0] pwdata           = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  battery_led_bar_animator_top #(
    .LED_COUNT(BAR_COUNT)
  ) dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // LED bar state as the block should hold it
  logic [CFG_W-1:0] step_charge = 16'd200;
  logic [CFG_W-1:0] step_empty  = 16'd500;
  logic [CFG_W-1:0] crit_gap    = 16'd2000;
  logic [CFG_W-1:0] crit_dark   = 16'd200;

  logic [VAL_W-1:0]   charge_lvl    = '0;
  logic [VAL_W-1:0]   num_shown     = '0;
  logic               soc_mode      = 1'b0;
  logic               chg_anim_on   = 1'b0;
  logic               crit_anim_on  = 1'b0;
  logic               empty_anim_on = 1'b0;
  logic [PHASE_W-1:0] phase_cnt     = '0;
  logic [CFG_W-1:0]   anim_ticks    = '0;
  logic               boot_on       = 1'b1;
  logic [SU_W-1:0]    boot_ticks    = '0;
  logic [LED_W-1:0]   pins_q        = '1;

  bar_req_t pending_reqs[$];
  res_t     expected_frames[$];
  bar_req_t presented_req;

  int unsigned fail_count   = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned stuck_cycles = 0;
  logic        idle_on      = 1'b1;
  logic        calm         = 1'b0;
  logic        idling;
  logic        took_in;
  logic        took_out;
  logic        busy;

  assign idling   = idle_on && !calm;
  assign took_in  = in_valid_i && !in_stall_o;
  assign took_out = out_valid_o && !out_stall_i;
  assign busy     = pending_reqs.size() != 0 || in_valid_i || expected_frames.size() != 0;

  function automatic logic [LED_W-1:0] soc_bars();
    logic [LED_W-1:0] bars;
    logic [LED_W-1:0] keep;
    int unsigned      nxt;
    int unsigned      i;
    bars = '0;
    keep = '0;
    for (i = 0; i < BAR_COUNT && i < LED_W; i++) begin
      if (charge_lvl > i * (100 / BAR_COUNT)) bars[i] = 1'b1;
    end
    if (chg_anim_on) begin
      if (anim_ticks > step_charge) begin
        nxt        = phase_cnt + 1;
        phase_cnt  = (nxt >= BAR_COUNT) ? '0 : nxt[PHASE_W-1:0];
        anim_ticks = '0;
      end
      for (i = 0; i < LED_W; i++) keep[i] = (i < phase_cnt);
      bars &= keep;
    end else if (empty_anim_on) begin
      if (anim_ticks > step_empty) begin
        phase_cnt  = (phase_cnt == 0) ? 3'd1 : 3'd0;
        anim_ticks = '0;
      end
      if (phase_cnt == 0) bars = '0;
    end else if (crit_anim_on) begin
      if (phase_cnt == 0) begin
        if (anim_ticks > crit_gap) begin
          phase_cnt  = 3'd1;
          anim_ticks = '0;
        end
      end else if (phase_cnt == 1) begin
        bars = '0;
        if (anim_ticks > crit_dark) begin
          phase_cnt  = 3'd0;
          anim_ticks = '0;
        end
      end
    end
    return bars;
  endfunction

  function automatic void refresh_pins();
    if (boot_on) begin
      if (boot_ticks > SU_END) boot_on = 1'b0;
      else if (boot_ticks > SU_DARK) pins_q = '0;
      else pins_q = '1;
    end else begin
      pins_q = soc_mode ? soc_bars() : num_shown[LED_W-1:0];
    end
  endfunction

  function automatic res_t step_led_bar(input bar_req_t r);
    res_t frame;
    logic run;
    logic restart;
    run     = 1'b1;
    restart = 1'b1;
    case (r.action)
      ACT_TICK: begin
        restart = 1'b0;
        if (anim_ticks != ELAPSED_MAX) anim_ticks++;
        if (boot_on && boot_ticks != SU_MAX) boot_ticks++;
      end
      ACT_SET_CHARGE: begin
        charge_lvl = r.charge;
        soc_mode   = 1'b1;
      end
      ACT_SET_NUMBER: begin
        num_shown = r.number;
        soc_mode  = 1'b0;
      end
      ACT_CHARGING: chg_anim_on   = r.flag;
      ACT_CRITICAL: crit_anim_on  = r.flag;
      ACT_EMPTY:    empty_anim_on = r.flag;
      default: begin
        run     = 1'b0;
        restart = 1'b0;
      end
    endcase
    if (restart) begin
      phase_cnt  = '0;
      anim_ticks = '0;
    end
    if (run) refresh_pins();
    frame.led     = pins_q;
    frame.startup = boot_on;
    return frame;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= !calm;
      if (took_in) expected_frames.push_back(step_led_bar(presented_req));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
          gap_left   <= $urandom_range(0, 11);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          presented_req     = pending_reqs.pop_front();
          in_valid_i       <= 1'b1;
          action_i         <= presented_req.action;
          charge_percent_i <= presented_req.charge;
          number_value_i   <= presented_req.number;
          flag_value_i     <= presented_req.flag;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (took_out) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result led_pattern %h in_startup %b",
                   $time, led_pattern_o, in_startup_o);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          if (led_pattern_o !== want.led) begin
            $display("%0t: led_pattern expected %h actual %h", $time, want.led, led_pattern_o);
            fail_count++;
          end
          if (in_startup_o !== want.startup) begin
            $display("%0t: in_startup expected %b actual %b",
                     $time, want.startup, in_startup_o);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left  <= $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if (took_in || took_out || !busy) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic [2:0] act, input logic [VAL_W-1:0] chg,
                          input logic [VAL_W-1:0] num, input logic flg);
    bar_req_t r;
    r.action = act;
    r.charge = chg;
    r.number = num;
    r.flag   = flg;
    pending_reqs.push_back(r);
  endtask

  task automatic push_rand(input logic [2:0] act);
    push_req(act, VAL_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic push_ticks(input int unsigned n);
    repeat (n) push_rand(ACT_TICK);
  endtask

  task automatic push_flag(input logic [2:0] act, input logic flg);
    push_req(act, VAL_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, 255)), flg);
  endtask

  task automatic push_charge(input logic [VAL_W-1:0] chg);
    push_req(ACT_SET_CHARGE, chg, VAL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_number(input logic [VAL_W-1:0] num);
    push_req(ACT_SET_NUMBER, VAL_W'($urandom_range(0, 255)), num, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [VAL_W-1:0] pick_charge();
    int v;
    if ($urandom_range(0, 1) == 0) return VAL_W'($urandom_range(0, 255));
    v = (100 / BAR_COUNT) * $urandom_range(0, BAR_COUNT) + $urandom_range(0, 2) - 1;
    return v[VAL_W-1:0];
  endfunction

  // Mostly charge-mode sequences: set events followed by runs of ticks
  task automatic random_burst(input int unsigned target);
    int unsigned made;
    int unsigned pick;
    int unsigned run;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 99);
      run  = 1;
      if (pick < 8) begin
        push_rand(ACT_SET_NUMBER);
      end else if (pick < 28) begin
        push_charge(pick_charge());
      end else if (pick < 52) begin
        case ($urandom_range(0, 2))
          0:       push_rand(ACT_CHARGING);
          1:       push_rand(ACT_CRITICAL);
          default: push_rand(ACT_EMPTY);
        endcase
      end else if (pick < 54) begin
        push_rand($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7);
      end else begin
        run = $urandom_range(1, 16);
        push_ticks(run);
      end
      made += run;
    end
  endtask

  task automatic wait_all_results();
    while (pending_reqs.size() != 0 || in_valid_i || expected_frames.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_step_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] word;
    word            = $urandom;
    word[CFG_W-1:0] = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHARGE_STEP:  step_charge = val;
      REG_EMPTY_STEP:   step_empty  = val;
      REG_CRIT_SPACING: crit_gap    = val;
      REG_CRIT_BLINK:   crit_dark   = val;
      default: ;
    endcase
  endtask

  task automatic write_all_steps(input logic [CFG_W-1:0] chg, input logic [CFG_W-1:0] emp,
                                 input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] dark);
    write_step_reg(REG_CHARGE_STEP, chg);
    write_step_reg(REG_EMPTY_STEP, emp);
    write_step_reg(REG_CRIT_SPACING, gap);
    write_step_reg(REG_CRIT_BLINK, dark);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // startup: set events are stored but the bar stays in its lamp test
    push_rand(ACT_SPARE_6);
    push_rand(ACT_SPARE_7);
    push_number(8'hAA);
    push_charge(8'hFF);
    push_flag(ACT_CHARGING, 1'b1);
    push_flag(ACT_CHARGING, 1'b0);
    push_ticks(1002);
    wait_all_results();

    push_number(8'h55);
    push_number(8'hFF);
    push_number(8'h00);
    push_charge(8'd0);
    push_charge(8'd20);
    push_charge(8'd21);
    push_charge(8'd81);
    push_charge(8'd100);
    push_charge(8'd255);
    push_ticks(3);
    push_flag(ACT_CHARGING, 1'b1);
    push_ticks(2);
    push_flag(ACT_EMPTY, 1'b1);
    push_flag(ACT_CHARGING, 1'b0);
    push_flag(ACT_CRITICAL, 1'b1);
    push_flag(ACT_EMPTY, 1'b0);
    push_ticks(2);
    push_rand(ACT_SPARE_7);
    push_flag(ACT_CRITICAL, 1'b0);
    wait_all_results();

    write_all_steps(16'd3, 16'd2, 16'd4, 16'd1);
    random_burst(100);
    wait_all_results();

    write_all_steps(16'd0, 16'd0, 16'd0, 16'd0);
    random_burst(60);
    wait_all_results();

    write_all_steps(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_burst(50);
    push_charge(8'd100);
    push_flag(ACT_CHARGING, 1'b1);
    push_ticks(20);
    wait_all_results();

    idle_on = 1'b0;
    write_all_steps(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)),
                    CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 6)));
    random_burst(100);
    wait_all_results();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
